FILE: rtl/sprite_scanline_renderer_defines.svh
// assertion helpers for the sprite line renderer
`ifndef SPRITE_SCANLINE_RENDERER_DEFINES_SVH
`define SPRITE_SCANLINE_RENDERER_DEFINES_SVH

// plain implication check, clocked on clk with reset masking
`define SSR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication check
`define SSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ssr_pkg.sv
`timescale 1ns / 1ps
package ssr_pkg;

    localparam int TableEntriesDef = 40;
    localparam int PerLineLimitDef = 10;
    localparam int LineWidthDef    = 160;
    localparam int TileBytes       = 4096;
    localparam int TileAddrW       = 12;

    localparam logic [2:0] MODE_TABLE_WR = 3'd0;
    localparam logic [2:0] MODE_TILE_WR  = 3'd1;
    localparam logic [2:0] MODE_BG_LOAD  = 3'd2;
    localparam logic [2:0] MODE_RENDER   = 3'd3;
    localparam logic [2:0] MODE_READ     = 3'd4;

    localparam logic [1:0] REG_SPRITES_ON   = 2'd0;
    localparam logic [1:0] REG_TALL_SPRITES = 2'd1;
    localparam logic [1:0] REG_PALETTE_ZERO = 2'd2;
    localparam logic [1:0] REG_PALETTE_ONE  = 2'd3;

    localparam int ATTR_BEHIND = 7;
    localparam int ATTR_VFLIP  = 6;
    localparam int ATTR_HFLIP  = 5;
    localparam int ATTR_PAL    = 4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  table_byte;
        logic [11:0] tile_byte;
        logic [7:0]  pixel_x;
        logic [7:0]  line;
        logic [7:0]  value;
    } ssr_in_t;

    typedef struct packed {
        logic [1:0] shade;
        logic [3:0] sprites_found;
    } ssr_out_t;

    typedef struct packed {
        logic       sprites_on;
        logic       tall_sprites;
        logic [7:0] palette_zero;
        logic [7:0] palette_one;
    } ssr_cfg_t;

endpackage

FILE: rtl/ssr_regs.sv
`timescale 1ns / 1ps
module ssr_regs
    import ssr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output ssr_cfg_t    cfg
);

    ssr_cfg_t   cfg_reg;
    logic [1:0] idx;
    logic       wr;

    assign idx    = paddr[3:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sprites_on   <= 1'b0;
            cfg_reg.tall_sprites <= 1'b0;
            cfg_reg.palette_zero <= 8'hFF;
            cfg_reg.palette_one  <= 8'hFF;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            case (idx)
                REG_SPRITES_ON:   cfg_reg.sprites_on   <= pwdata[0];
                REG_TALL_SPRITES: cfg_reg.tall_sprites <= pwdata[0];
                REG_PALETTE_ZERO: cfg_reg.palette_zero <= pwdata[7:0];
                REG_PALETTE_ONE:  cfg_reg.palette_one  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            REG_SPRITES_ON:   prdata[0]   = cfg_reg.sprites_on;
            REG_TALL_SPRITES: prdata[0]   = cfg_reg.tall_sprites;
            REG_PALETTE_ZERO: prdata[7:0] = cfg_reg.palette_zero;
            REG_PALETTE_ONE:  prdata[7:0] = cfg_reg.palette_one;
            default:          prdata      = '0;
        endcase
    end

endmodule

FILE: rtl/sprite_scanline_renderer.sv
`timescale 1ns / 1ps
// sprite line renderer: sprite table, tile store and line buffer with a small sequencer
// input channel in_valid/in_stall carries one command (mode, addresses, line, value);
// output channel out_valid/out_stall returns one result per command (shade, count)
// config must be written through the register port only while the block is idle; the block does not enforce this
// after reset a clearing pass runs over the tile store, one byte a cycle, during which
// in_stall stays high; table and buffer clear by sweep alongside
// a render scans the table entries, then for each kept sprite does four table reads and
// two tile reads, then per pixel a buffer read, compare and write through one port
// one command is worked at a time; in_stall is high while a command is in flight
// the result sits in an output register; while out_stall is high it holds and
// no new command is taken
module sprite_scanline_renderer
    import ssr_pkg::*;
#(
    parameter int TABLE_ENTRIES  = TableEntriesDef,
    parameter int PER_LINE_LIMIT = PerLineLimitDef,
    parameter int LINE_WIDTH     = LineWidthDef
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  ssr_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output ssr_out_t    out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
`include "sprite_scanline_renderer_defines.svh"

    localparam int TabDepth = TABLE_ENTRIES * 4;
    localparam int TabAW    = $clog2(TabDepth);
    localparam int EntW     = $clog2(TABLE_ENTRIES + 1);
    localparam int KeepW    = $clog2(PER_LINE_LIMIT + 1);
    localparam int KeepIW   = (PER_LINE_LIMIT > 1) ? $clog2(PER_LINE_LIMIT) : 1;
    localparam int BufAW    = $clog2(LINE_WIDTH);

    ssr_cfg_t cfg;

    ssr_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    // memories
    logic [7:0] tab_mem  [TabDepth];
    logic [7:0] tile_mem [TileBytes];
    logic [1:0] buf_mem  [LINE_WIDTH];
    logic [EntW-1:0] kept_mem [PER_LINE_LIMIT];

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_DRAW_Y, S_DRAW_X, S_DRAW_T,
        S_DRAW_A, S_TILE_LO, S_TILE_HI, S_PIX_RD, S_PIX_WAIT, S_PIX_WR,
        S_READ_WAIT, S_DONE, S_OUT
    } state_t;

    state_t state_reg;
    ssr_in_t cmd_reg;
    logic [TileAddrW-1:0] clr_reg;
    logic [EntW-1:0]  ent_reg;
    logic [KeepW-1:0] nkept_reg;
    logic [KeepIW-1:0] kidx_reg;
    logic [KeepW-1:0] kcnt_reg;
    logic [7:0] sy_reg, sx_reg, stile_reg, attr_reg;
    logic [7:0] lo_reg, hi_reg;
    logic [3:0] p_reg;
    logic [8:0] col_reg;
    logic [1:0] color_reg;
    logic       buf_ra_settled_reg;
    ssr_out_t   out_reg;
    logic       out_valid_reg;

    // memory ports
    logic [TabAW-1:0] tab_ra;
    logic [7:0] tab_rd_reg;
    logic [TileAddrW-1:0] tile_ra;
    logic [7:0] tile_rd_reg;
    logic [BufAW-1:0] buf_ra;
    logic [1:0] buf_rd_reg;
    logic [EntW-1:0] kept_rd;

    logic tab_we, tile_we, buf_we;
    logic [TabAW-1:0] tab_wa;
    logic [TileAddrW-1:0] tile_wa;
    logic [BufAW-1:0] buf_wa;
    logic [7:0] tab_wd, tile_wd;
    logic [1:0] buf_wd;

    logic [3:0] height;
    logic [8:0] line16;
    logic       overlap;
    logic [3:0] row, row_f;
    logic [7:0] tile_eff;
    logic [TileAddrW-1:0] tile_base;
    logic [2:0] bitn;
    logic [1:0] color_now;
    logic [7:0] pal;
    logic [1:0] shade_new;
    logic       col_ok;
    logic       accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign height  = cfg.tall_sprites ? 4'd15 : 4'd7;
    assign line16  = {1'b0, cmd_reg.line} + 9'd16;
    assign overlap = (line16 >= {1'b0, tab_rd_reg}) &&
                     (line16 <= {1'b0, tab_rd_reg} + {5'd0, height});
    assign row     = 4'(line16 - {1'b0, sy_reg});
    assign row_f   = attr_reg[ATTR_VFLIP] ? (height - row) : row;
    assign tile_eff = cfg.tall_sprites ? {stile_reg[7:1], 1'b0} : stile_reg;
    assign tile_base = {tile_eff, 4'd0} + {7'd0, row_f, 1'b0};
    assign bitn    = 3'(4'd7 - p_reg);
    assign color_now = {hi_reg[bitn], lo_reg[bitn]};
    assign pal     = attr_reg[ATTR_PAL] ? cfg.palette_one : cfg.palette_zero;
    assign shade_new = pal[{color_reg, 1'b0} +: 2];
    assign col_ok  = (col_reg < 9'(LINE_WIDTH));
    assign kept_rd = kept_mem[kidx_reg];

    always_ff @(posedge clk)
    begin
        if (tab_we)
            tab_mem[tab_wa] <= tab_wd;
        tab_rd_reg <= tab_mem[tab_ra];
        if (tile_we)
            tile_mem[tile_wa] <= tile_wd;
        tile_rd_reg <= tile_mem[tile_ra];
        if (buf_we)
            buf_mem[buf_wa] <= buf_wd;
        buf_rd_reg <= buf_mem[buf_ra];
    end

    // memory port control
    always_comb
    begin
        tab_we = 1'b0;  tab_wa = '0;  tab_wd = '0;
        tile_we = 1'b0; tile_wa = clr_reg; tile_wd = '0;
        buf_we = 1'b0;  buf_wa = '0;  buf_wd = '0;
        tab_ra = '0;
        tile_ra = tile_base;
        buf_ra = BufAW'(col_reg);
        case (state_reg)
            S_CLEAR:
            begin
                tile_we = 1'b1;
                if (32'(clr_reg) < TabDepth)
                begin
                    tab_we = 1'b1;
                    tab_wa = TabAW'(clr_reg);
                end
                if (32'(clr_reg) < LINE_WIDTH)
                begin
                    buf_we = 1'b1;
                    buf_wa = BufAW'(clr_reg);
                end
            end
            S_IDLE:
            begin
                tab_ra = TabAW'({ent_reg, 2'b00});
                buf_ra = BufAW'(in_data.pixel_x);
            end
            S_SCAN_RD, S_SCAN_CHK:
                tab_ra = TabAW'({ent_reg, 2'b00});
            S_DRAW_Y: tab_ra = TabAW'({kept_rd, 2'b00});
            S_DRAW_X: tab_ra = TabAW'({kept_rd, 2'b01});
            S_DRAW_T: tab_ra = TabAW'({kept_rd, 2'b10});
            S_DRAW_A: tab_ra = TabAW'({kept_rd, 2'b11});
            S_PIX_RD:
            begin
                if (p_reg == 4'd0)
                    tile_ra = tile_base + 12'd1;
            end
            S_READ_WAIT:
                buf_ra = BufAW'(cmd_reg.pixel_x);
            S_PIX_WR:
            begin
                if (buf_ra_settled_reg && col_ok && color_reg != 2'd0 &&
                    !(attr_reg[ATTR_BEHIND] && buf_rd_reg != 2'd0))
                begin
                    buf_we = 1'b1;
                    buf_wa = BufAW'(col_reg);
                    buf_wd = shade_new;
                end
            end
            S_DONE:
            begin
                case (cmd_reg.mode)
                    MODE_TABLE_WR:
                    begin
                        tab_we = (32'(cmd_reg.table_byte) < TabDepth);
                        tab_wa = TabAW'(cmd_reg.table_byte);
                        tab_wd = cmd_reg.value;
                    end
                    MODE_TILE_WR:
                    begin
                        tile_we = 1'b1;
                        tile_wa = cmd_reg.tile_byte;
                        tile_wd = cmd_reg.value;
                    end
                    MODE_BG_LOAD:
                    begin
                        buf_we = (32'(cmd_reg.pixel_x) < LINE_WIDTH);
                        buf_wa = BufAW'(cmd_reg.pixel_x);
                        buf_wd = cmd_reg.value[1:0];
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            ent_reg       <= '0;
            nkept_reg     <= '0;
            kidx_reg      <= '0;
            kcnt_reg      <= '0;
            buf_ra_settled_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == TileAddrW'(TileBytes - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    ent_reg   <= '0;
                    nkept_reg <= '0;
                    kidx_reg  <= '0;
                    kcnt_reg  <= '0;
                    if (accept)
                    begin
                        cmd_reg <= in_data;
                        if (in_data.mode == MODE_RENDER && cfg.sprites_on)
                            state_reg <= S_SCAN_RD;
                        else if (in_data.mode == MODE_READ)
                            state_reg <= S_READ_WAIT;
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_SCAN_RD:
                    state_reg <= S_SCAN_CHK;
                S_SCAN_CHK:
                begin
                    if (overlap)
                    begin
                        kept_mem[KeepIW'(nkept_reg)] <= ent_reg;
                        nkept_reg <= nkept_reg + 1'b1;
                    end
                    ent_reg <= ent_reg + 1'b1;
                    if (ent_reg == EntW'(TABLE_ENTRIES - 1) ||
                        (overlap && nkept_reg == KeepW'(PER_LINE_LIMIT - 1)))
                    begin
                        if (overlap || nkept_reg != '0)
                            state_reg <= S_DRAW_Y;
                        else
                            state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_SCAN_RD;
                end
                S_DRAW_Y:
                begin
                    // read of y issued here, each byte arrives in the cycle after its address
                    state_reg <= S_DRAW_X;
                end
                S_DRAW_X:
                begin
                    sy_reg    <= tab_rd_reg;
                    state_reg <= S_DRAW_T;
                end
                S_DRAW_T:
                begin
                    sx_reg    <= tab_rd_reg;
                    state_reg <= S_DRAW_A;
                end
                S_DRAW_A:
                begin
                    stile_reg <= tab_rd_reg;
                    state_reg <= S_TILE_LO;
                end
                S_TILE_LO:
                begin
                    attr_reg  <= tab_rd_reg;
                    state_reg <= S_TILE_HI;
                end
                S_TILE_HI:
                begin
                    state_reg <= S_PIX_RD;
                    p_reg     <= '0;
                end
                S_PIX_RD:
                begin
                    if (p_reg == 4'd0)
                    begin
                        lo_reg <= tile_rd_reg;
                        p_reg  <= 4'd8;
                    end
                    else
                    begin
                        hi_reg    <= tile_rd_reg;
                        p_reg     <= 4'd0;
                        state_reg <= S_PIX_WAIT;
                    end
                end
                S_PIX_WAIT:
                begin
                    // column and colour for pixel p, buffer read issued next cycle
                    col_reg   <= 9'({1'b0, sx_reg} - 9'd8 +
                                    (attr_reg[ATTR_HFLIP] ? 9'(4'd7 - p_reg) : 9'(p_reg)));
                    color_reg <= color_now;
                    state_reg <= S_PIX_WR;
                    kcnt_reg  <= kcnt_reg;
                end
                S_PIX_WR:
                begin
                    if (buf_ra_settled_reg)
                    begin
                        buf_ra_settled_reg <= 1'b0;
                        p_reg <= p_reg + 1'b1;
                        if (p_reg == 4'd7)
                        begin
                            if (kcnt_reg + 1'b1 == nkept_reg)
                                state_reg <= S_DONE;
                            else
                            begin
                                kcnt_reg  <= kcnt_reg + 1'b1;
                                kidx_reg  <= kidx_reg + 1'b1;
                                state_reg <= S_DRAW_Y;
                            end
                        end
                        else
                            state_reg <= S_PIX_WAIT;
                    end
                    else
                        buf_ra_settled_reg <= 1'b1;
                end
                S_READ_WAIT:
                    state_reg <= S_DONE;
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    out_reg.shade <= (cmd_reg.mode == MODE_READ &&
                                      32'(cmd_reg.pixel_x) < LINE_WIDTH) ? buf_rd_reg : 2'd0;
                    out_reg.sprites_found <= (cmd_reg.mode == MODE_RENDER) ?
                                             4'(nkept_reg) : 4'd0;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    `SSR_ASSERT_IMP(a_stall_busy, state_reg != S_IDLE, in_stall, "not stalled while busy")
    `SSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data),
                     "result dropped under stall")
    `SSR_ASSERT_IMP(a_found_range, out_valid, out_data.sprites_found <= 4'(PER_LINE_LIMIT),
                    "too many sprites reported")

endmodule
